// ===== src/stick_average_calibrate_scale_assert.svh =====
// Assertion macros shared by the checker
`ifndef STICK_AVERAGE_CALIBRATE_SCALE_ASSERT_SVH
`define STICK_AVERAGE_CALIBRATE_SCALE_ASSERT_SVH

// Check a property outside reset
`define SACS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sacs check failed");

// Check a property at every edge, reset included
`define SACS_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("sacs reset check failed");

`endif

// ===== src/sacs_pkg.sv =====
package sacs_pkg;

	localparam int WIN_LOG2 = 3;
	localparam int WINDOW = 1 << WIN_LOG2;
	localparam int NUM_CH = 3;
	localparam int SMP_W = 16;
	localparam int SUM_W = SMP_W + WIN_LOG2 + 1;
	localparam int OUT_W = 8;
	localparam int NUM_W = SMP_W + OUT_W;
	localparam int SPAN_W = SMP_W + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int CH_W = 2;
	localparam logic [OUT_W-1:0] RANGE_RESET = 8'd255;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic avg;
		logic mul;
		logic div_step;
		logic store;
		logic load_out;
		logic [CH_W-1:0] ch;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage

// ===== src/sacs_ctrl.sv =====
module sacs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sacs_pkg::sts_t sts,
	output sacs_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_AVG   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_STORE = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [sacs_pkg::CH_W-1:0] ch_q;
	logic [sacs_pkg::CH_W-1:0] ch_d;
	logic [sacs_pkg::STEP_W-1:0] step_q;
	logic [sacs_pkg::STEP_W-1:0] step_d;

	assign in_stall = (state_q != ST_IDLE);

	// Sequence one word through average, then each channel through multiply, divide and store, then hand it off
	always_comb begin
		state_d = state_q;
		ch_d = ch_q;
		step_d = step_q;
		cmd = '0;
		cmd.ch = ch_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.avg = 1'b1;
				ch_d = '0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				step_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 1'b1;
				if (step_q == sacs_pkg::STEP_W'(sacs_pkg::DIV_STEPS - 1)) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (ch_q == sacs_pkg::CH_W'(sacs_pkg::NUM_CH - 1)) begin
					state_d = ST_DONE;
				end else begin
					ch_d = ch_q + 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			ch_q <= ch_d;
			step_q <= step_d;
		end
	end

endmodule

// ===== src/sacs_dp.sv =====
module sacs_dp (
	input  logic clk,
	input  logic arst_n,
	input  sacs_pkg::cmd_t cmd,
	output sacs_pkg::sts_t sts,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic signed [15:0] throttle_sample,
	input  logic signed [15:0] pitch_sample,
	input  logic signed [15:0] roll_sample,
	input  logic calibrate,
	input  logic send_enable,
	input  logic command_pending,
	input  logic full_throttle,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] throttle_out,
	output logic [7:0] pitch_out,
	output logic [7:0] roll_out,
	output logic updated
);

	localparam int OW = sacs_pkg::OUT_W;
	localparam int NW = sacs_pkg::NUM_W;
	localparam int PW = sacs_pkg::SPAN_W;

	sacs_pkg::smp_t hist_q [sacs_pkg::NUM_CH][sacs_pkg::WINDOW];
	sacs_pkg::sum_t sum_q [sacs_pkg::NUM_CH];
	sacs_pkg::smp_t lo_q [sacs_pkg::NUM_CH];
	sacs_pkg::smp_t hi_q [sacs_pkg::NUM_CH];
	sacs_pkg::smp_t avg_q [sacs_pkg::NUM_CH];
	logic [OW-1:0] res_q [sacs_pkg::NUM_CH];
	sacs_pkg::smp_t samp [sacs_pkg::NUM_CH];
	sacs_pkg::smp_t avg_n [sacs_pkg::NUM_CH];
	logic [OW-1:0] range_q;
	logic cal_q;
	logic upd_q;
	logic full_q;
	logic [NW-1:0] num_q;
	logic [PW-1:0] span_q;
	logic [PW-1:0] rem_q;
	logic zero_q;
	logic out_valid_q;

	logic signed [PW-1:0] diff;
	logic signed [PW-1:0] span_s;
	logic signed [NW+1:0] prod;
	logic [PW:0] trial;
	logic [PW:0] trial_sub;
	logic [NW-1:0] quo;
	logic [OW-1:0] clamped;

	assign samp[0] = throttle_sample;
	assign samp[1] = pitch_sample;
	assign samp[2] = roll_sample;

	// Average each channel, truncating toward zero
	always_comb begin
		for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
			avg_n[c] = sacs_pkg::smp_t'((sum_q[c] + (sum_q[c][sacs_pkg::SUM_W-1]
				? sacs_pkg::sum_t'(sacs_pkg::WINDOW - 1) : sacs_pkg::sum_t'(0)))
				>>> sacs_pkg::WIN_LOG2);
		end
	end

	// Offset times range, and the span of the selected channel
	assign diff = sacs_pkg::SPAN_W'(avg_q[cmd.ch]) - sacs_pkg::SPAN_W'(lo_q[cmd.ch]);
	assign span_s = sacs_pkg::SPAN_W'(hi_q[cmd.ch]) - sacs_pkg::SPAN_W'(lo_q[cmd.ch]);
	assign prod = (NW+2)'(diff) * (NW+2)'($signed({1'b0, range_q}));

	// One restoring divide step
	assign trial = {rem_q, num_q[NW-1]};
	assign trial_sub = trial - {1'b0, span_q};

	// Clamp the quotient to the output range
	assign quo = zero_q ? '0 : num_q;
	assign clamped = (quo > NW'(range_q)) ? range_q : quo[OW-1:0];

	// Hold history, sums, tracked limits, range and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
				for (int i = 0; i < sacs_pkg::WINDOW; i++) begin
					hist_q[c][i] <= '0;
				end
				sum_q[c] <= '0;
				lo_q[c] <= '0;
				hi_q[c] <= sacs_pkg::smp_t'(1);
			end
			range_q <= sacs_pkg::RANGE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				range_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
					hist_q[c][0] <= samp[c];
					for (int i = 1; i < sacs_pkg::WINDOW; i++) begin
						hist_q[c][i] <= hist_q[c][i-1];
					end
					sum_q[c] <= sum_q[c] + sacs_pkg::SUM_W'(samp[c])
						- sacs_pkg::SUM_W'(hist_q[c][sacs_pkg::WINDOW-1]);
				end
			end
			if (cmd.avg && cal_q) begin
				for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
					if (avg_n[c] > hi_q[c]) begin
						hi_q[c] <= avg_n[c];
					end
					if (avg_n[c] < lo_q[c]) begin
						lo_q[c] <= avg_n[c];
					end
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cal_q <= calibrate;
			upd_q <= send_enable && !command_pending;
			full_q <= full_throttle;
		end
		if (cmd.avg) begin
			for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
				avg_q[c] <= avg_n[c];
			end
		end
		if (cmd.mul) begin
			zero_q <= (span_s <= 0) || (prod <= 0);
			num_q <= prod[NW-1:0];
			span_q <= span_s;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			if (!trial_sub[PW]) begin
				rem_q <= trial_sub[PW-1:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[PW-1:0];
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.store) begin
			res_q[cmd.ch] <= (cmd.ch == '0 && full_q) ? range_q : clamped;
		end
		if (cmd.load_out) begin
			throttle_out <= upd_q ? res_q[0] : '0;
			pitch_out <= upd_q ? res_q[1] : '0;
			roll_out <= upd_q ? res_q[2] : '0;
			updated <= upd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sts.out_full = out_valid_q;

endmodule

// ===== src/stick_average_calibrate_scale.sv =====
// Each word is accepted, then averaged; each of the three channels is then multiplied,
// divided by the shared restoring divider in 24 steps, and stored; then the word is handed off.
// Input stalls from acceptance until handoff, so a new word is taken only while idle.
// A result waits in the output register while the next word is taken; that word stalls
// at handoff until the register drains. Reset clears history and sums, sets limits to 0
// (low) and 1 (high), and sets range to 255.
module stick_average_calibrate_scale (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [15:0] throttle_sample,
	input  logic signed [15:0] pitch_sample,
	input  logic signed [15:0] roll_sample,
	input  logic calibrate,
	input  logic send_enable,
	input  logic command_pending,
	input  logic full_throttle,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] throttle_out,
	output logic [7:0] pitch_out,
	output logic [7:0] roll_out,
	output logic updated
);

	sacs_pkg::cmd_t cmd;
	sacs_pkg::sts_t sts;

	sacs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sacs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.throttle_sample (throttle_sample),
		.pitch_sample    (pitch_sample),
		.roll_sample     (roll_sample),
		.calibrate       (calibrate),
		.send_enable     (send_enable),
		.command_pending (command_pending),
		.full_throttle   (full_throttle),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.throttle_out    (throttle_out),
		.pitch_out       (pitch_out),
		.roll_out        (roll_out),
		.updated         (updated)
	);

endmodule

// ===== src/sacs_chk.sv =====
`include "stick_average_calibrate_scale_assert.svh"

module sacs_chk (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic in_valid,
	input logic in_stall,
	input logic signed [15:0] throttle_sample,
	input logic signed [15:0] pitch_sample,
	input logic signed [15:0] roll_sample,
	input logic calibrate,
	input logic send_enable,
	input logic command_pending,
	input logic full_throttle,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] throttle_out,
	input logic [7:0] pitch_out,
	input logic [7:0] roll_out,
	input logic updated
);

	// hold a stalled result word
	`SACS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
	// drop values of a word that is not marked updated
	`SACS_ASSERT(a_zero_not_upd, out_valid && !updated |-> (throttle_out | pitch_out | roll_out) == 8'd0)
	// busy right after taking a word
	`SACS_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)
	// no result word after a reset edge
	`SACS_ASSERT_RST(a_reset_idle, !arst_n |=> !out_valid)

endmodule

bind stick_average_calibrate_scale sacs_chk u_sacs_chk (.*);
